// ----- rtl/rna_pkg.sv -----
// Package: shared types and constants for the rational number ALU.
`timescale 1ns / 1ps
package rna_pkg;
   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_DIV  = 3'd3;
   localparam logic [2:0] CMD_CMP  = 3'd4;
   localparam logic [2:0] CMD_NORM = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_MUL, S_COMB, S_GCD_START, S_GCD_DIV,
      S_GCD_STEP, S_QUO_START, S_QUO_DIV, S_QUO_NEXT, S_CHECK, S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic comb;
      logic gcd_start;
      logic div_start;
      logic div_step;
      logic gcd_step;
      logic quo_sel_den;
      logic quo_take;
      logic check;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic early_done;
      logic gcd_zero;
      logic div_done;
      logic quo_second;
   } stat_type;
endpackage

// ----- rtl/rna_ctrl.sv -----
// Controller: sequences load, multiply, gcd and reduction steps.
`timescale 1ns / 1ps
module rna_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rna_pkg::stat_type stat,
   output rna_pkg::cmd_type  cmd
);
   rna_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rna_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rna_pkg::S_IDLE:      if (start) state_in = rna_pkg::S_LOAD;
         rna_pkg::S_LOAD:      state_in = rna_pkg::S_MUL;
         rna_pkg::S_MUL:       state_in = rna_pkg::S_COMB;
         rna_pkg::S_COMB: begin
            if (stat.early_done) state_in = rna_pkg::S_DONE;
            else state_in = rna_pkg::S_GCD_START;
         end
         rna_pkg::S_GCD_START: begin
            if (stat.gcd_zero) state_in = rna_pkg::S_QUO_START;
            else state_in = rna_pkg::S_GCD_DIV;
         end
         rna_pkg::S_GCD_DIV:   if (stat.div_done) state_in = rna_pkg::S_GCD_STEP;
         rna_pkg::S_GCD_STEP:  state_in = rna_pkg::S_GCD_START;
         rna_pkg::S_QUO_START: state_in = rna_pkg::S_QUO_DIV;
         rna_pkg::S_QUO_DIV:   if (stat.div_done) state_in = rna_pkg::S_QUO_NEXT;
         rna_pkg::S_QUO_NEXT: begin
            if (stat.quo_second) state_in = rna_pkg::S_CHECK;
            else state_in = rna_pkg::S_QUO_START;
         end
         rna_pkg::S_CHECK:     state_in = rna_pkg::S_DONE;
         rna_pkg::S_DONE:      state_in = rna_pkg::S_IDLE;
         default:              state_in = rna_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != rna_pkg::S_IDLE);
      case (state_ff)
         rna_pkg::S_IDLE:      cmd.load = start;
         rna_pkg::S_LOAD:      cmd.mul = 1'b1;
         rna_pkg::S_MUL:       cmd.comb = 1'b1;
         rna_pkg::S_GCD_START: cmd.div_start = ~stat.gcd_zero;
         rna_pkg::S_GCD_DIV:   cmd.div_step = 1'b1;
         rna_pkg::S_GCD_STEP:  cmd.gcd_step = 1'b1;
         rna_pkg::S_QUO_START: begin
            cmd.div_start   = 1'b1;
            cmd.quo_sel_den = stat.quo_second;
         end
         rna_pkg::S_QUO_DIV:   cmd.div_step = 1'b1;
         rna_pkg::S_QUO_NEXT:  cmd.quo_take = 1'b1;
         rna_pkg::S_CHECK:     cmd.check = 1'b1;
         rna_pkg::S_DONE:      cmd.emit = 1'b1;
         default:              cmd = '0;
      endcase
      cmd.gcd_start = (state_ff == rna_pkg::S_COMB) && !stat.early_done;
   end
endmodule

// ----- rtl/rna_dp.sv -----
// Datapath: operand split, products, gcd and restoring divider.
`timescale 1ns / 1ps
module rna_dp #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  rna_pkg::cmd_type   cmd,
   output rna_pkg::stat_type  stat,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_cmp_less,
   output logic               rsp_cmp_equal,
   output logic [1:0]         rsp_status,
   output logic               rsp_valid
);
   localparam int EW = (WIDTH < 8) ? 8 : ((WIDTH > 32) ? 32 : WIDTH);
   localparam int PW = 2 * EW + 1;
   localparam int CW = $clog2(PW + 1);
   localparam logic [PW-1:0] HALF = PW'(1) << (EW - 1);

   logic [2:0]    op_ff;
   logic          an_ff, bn_ff;
   logic [EW-1:0] anm_ff, adm_ff, bnm_ff, bdm_ff;
   logic [PW-1:0] x_ff, y_ff, d_ff;
   logic          neg_ff;
   logic [PW-1:0] n_ff, dn_ff;
   logic [PW-1:0] gx_ff, gy_ff;
   logic [PW-1:0] rem_ff, quo_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          sec_ff;
   logic [1:0]    st_ff;
   logic          lt_ff, eq_ff;
   logic signed [31:0] rnum_ff;
   logic [30:0]   rden_ff;
   logic          vld_ff;

   function automatic logic [EW:0] split_f(input logic [31:0] raw);
      logic [EW-1:0] v;
      logic [EW-1:0] m;
      v = raw[EW-1:0];
      m = v[EW-1] ? (~v + EW'(1)) : v;
      split_f = {v[EW-1], m};
   endfunction

   logic [EW:0]   sa_n, sa_d, sb_n, sb_d;
   logic          sub_neg;
   logic [PW-1:0] rem_sh, rem_tr;
   logic [31:0]   n_lo;
   logic          ovf;

   assign sa_n = split_f(req_a_num);
   assign sa_d = split_f(req_a_den);
   assign sb_n = split_f(req_b_num);
   assign sb_d = split_f(req_b_den);
   assign sub_neg = bn_ff ^ ((op_ff == rna_pkg::CMD_SUB) && bnm_ff != '0);

   assign rem_sh = {rem_ff[PW-2:0], quo_ff[PW-1]};
   assign rem_tr = rem_sh - dvs_ff;
   assign n_lo   = 32'(n_ff);
   assign ovf = (dn_ff == '0) || (dn_ff > HALF - PW'(1)) ||
                (n_ff > (neg_ff ? HALF : HALF - PW'(1)));

   assign stat.early_done = (st_ff != rna_pkg::ST_OK) || (op_ff == rna_pkg::CMD_CMP) ||
                            (op_ff > rna_pkg::CMD_NORM);
   assign stat.gcd_zero   = (gy_ff == '0);
   assign stat.div_done   = (cnt_ff == '0);
   assign stat.quo_second = sec_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_cmd;
         an_ff  <= (sa_n[EW] != sa_d[EW]) && sa_n[EW-1:0] != '0;
         bn_ff  <= (sb_n[EW] != sb_d[EW]) && sb_n[EW-1:0] != '0;
         anm_ff <= sa_n[EW-1:0];
         adm_ff <= sa_d[EW-1:0];
         bnm_ff <= sb_n[EW-1:0];
         bdm_ff <= sb_d[EW-1:0];
         lt_ff  <= 1'b0;
         eq_ff  <= 1'b0;
         st_ff  <= rna_pkg::ST_OK;
         sec_ff <= 1'b0;
      end
      if (cmd.mul) begin
         case (op_ff)
            rna_pkg::CMD_MUL: begin
               x_ff <= PW'(anm_ff) * PW'(bnm_ff);
               y_ff <= '0;
               d_ff <= PW'(adm_ff) * PW'(bdm_ff);
            end
            rna_pkg::CMD_DIV: begin
               x_ff <= PW'(anm_ff) * PW'(bdm_ff);
               y_ff <= '0;
               d_ff <= PW'(adm_ff) * PW'(bnm_ff);
            end
            rna_pkg::CMD_NORM: begin
               x_ff <= PW'(anm_ff);
               y_ff <= '0;
               d_ff <= PW'(adm_ff);
            end
            default: begin
               x_ff <= PW'(anm_ff) * PW'(bdm_ff);
               y_ff <= PW'(bnm_ff) * PW'(adm_ff);
               d_ff <= PW'(adm_ff) * PW'(bdm_ff);
            end
         endcase
         if (op_ff <= rna_pkg::CMD_NORM) begin
            if (adm_ff == '0 || (op_ff != rna_pkg::CMD_NORM && bdm_ff == '0) ||
                (op_ff == rna_pkg::CMD_DIV && bnm_ff == '0)) begin
               st_ff <= rna_pkg::ST_DIV0;
            end
         end
      end
      if (cmd.comb) begin
         case (op_ff)
            rna_pkg::CMD_ADD, rna_pkg::CMD_SUB: begin
               if (an_ff == sub_neg) begin
                  n_ff <= x_ff + y_ff;
                  neg_ff <= an_ff;
               end else if (x_ff >= y_ff) begin
                  n_ff <= x_ff - y_ff;
                  neg_ff <= an_ff;
               end else begin
                  n_ff <= y_ff - x_ff;
                  neg_ff <= sub_neg;
               end
            end
            rna_pkg::CMD_MUL, rna_pkg::CMD_DIV: begin
               n_ff <= x_ff;
               neg_ff <= an_ff ^ bn_ff;
            end
            default: begin
               n_ff <= x_ff;
               neg_ff <= an_ff;
            end
         endcase
         dn_ff <= d_ff;
         if (op_ff == rna_pkg::CMD_CMP && st_ff == rna_pkg::ST_OK) begin
            if (an_ff != bn_ff) begin
               lt_ff <= an_ff;
            end else begin
               lt_ff <= an_ff ? (x_ff > y_ff) : (x_ff < y_ff);
               eq_ff <= (x_ff == y_ff);
            end
         end
      end
      if (cmd.gcd_start) begin
         gx_ff <= n_ff;
         gy_ff <= dn_ff;
      end
      if (cmd.div_start) begin
         cnt_ff <= CW'(PW - 1);
         rem_ff <= '0;
         if (gy_ff != '0) begin
            quo_ff <= gx_ff;
            dvs_ff <= gy_ff;
         end else begin
            quo_ff <= cmd.quo_sel_den ? dn_ff : n_ff;
            dvs_ff <= (gx_ff == '0) ? PW'(1) : gx_ff;
         end
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (rem_sh >= dvs_ff) begin
            rem_ff <= rem_tr;
            quo_ff <= {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[PW-2:0], 1'b0};
         end
      end
      if (cmd.gcd_step) begin
         gx_ff <= gy_ff;
         gy_ff <= rem_ff;
      end
      if (cmd.quo_take) begin
         if (sec_ff) dn_ff <= quo_ff;
         else n_ff <= quo_ff;
         sec_ff <= ~sec_ff;
      end
      if (cmd.check) begin
         if (n_ff == '0) begin
            dn_ff  <= PW'(1);
            neg_ff <= 1'b0;
         end
      end
      if (cmd.emit) begin
         if (st_ff != rna_pkg::ST_OK || op_ff == rna_pkg::CMD_CMP ||
             op_ff > rna_pkg::CMD_NORM) begin
            rnum_ff <= '0;
            rden_ff <= 31'd1;
         end else if (ovf) begin
            rnum_ff <= '0;
            rden_ff <= 31'd1;
            st_ff   <= rna_pkg::ST_OVF;
         end else begin
            rnum_ff <= neg_ff ? (~n_lo + 32'd1) : n_lo;
            rden_ff <= 31'(dn_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.emit;
      end
   end

   assign rsp_res_num   = rnum_ff;
   assign rsp_res_den   = rden_ff;
   assign rsp_cmp_less  = lt_ff;
   assign rsp_cmp_equal = eq_ff;
   assign rsp_status    = st_ff;
   assign rsp_valid     = vld_ff;
endmodule

// ----- rtl/rational_number_alu.sv -----
// Top level: rational number ALU with gcd reduction.
//
// Usage: drive req_cmd and the four operand ports and raise start while
// busy is low; the beat is taken at that edge. busy stays high until the
// result is issued. One result beat per request appears on the rsp_ ports
// for exactly one cycle with rsp_valid high; the receiver cannot stall.
// Compare, error and unused codes skip the gcd steps and the divider.
// Other codes run one restoring divider pass over 2*W+1 bits (W is
// WIDTH clamped to 8..32) for each Euclid step and for each of the two
// quotients.
// The next request can be taken at the edge that ends the strobe cycle.
// Synchronous active-high reset returns the controller to idle and clears
// the result strobe.
`timescale 1ns / 1ps
module rational_number_alu #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_cmp_less,
   output logic               rsp_cmp_equal,
   output logic [1:0]         rsp_status
);
   rna_pkg::cmd_type  cmd;
   rna_pkg::stat_type stat;

   rna_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rna_dp #(.WIDTH(WIDTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_cmd       (req_cmd),
      .req_a_num     (req_a_num),
      .req_a_den     (req_a_den),
      .req_b_num     (req_b_num),
      .req_b_den     (req_b_den),
      .rsp_res_num   (rsp_res_num),
      .rsp_res_den   (rsp_res_den),
      .rsp_cmp_less  (rsp_cmp_less),
      .rsp_cmp_equal (rsp_cmp_equal),
      .rsp_status    (rsp_status),
      .rsp_valid     (rsp_valid)
   );
endmodule

// ----- test/tb.sv -----
// Testbench for the rational number ALU: random and directed beats checked by a predictor.
`timescale 1ns / 1ps
module tb;
   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               less;
      logic               equal;
      logic [1:0]         status;
   } frac_result_type;

   localparam longint unsigned HALF = 64'h8000_0000;

   class frac_scoreboard;
      frac_result_type pending[$];
      int              errors;

      function void split(input logic [31:0] raw, output bit neg, output longint unsigned mag);
         neg = raw[31];
         mag = neg ? longint'({1'b0, ~raw}) + 1 : longint'(raw);
      endfunction

      function void reduce(input bit neg, input longint unsigned n, input longint unsigned d,
                           inout frac_result_type r);
         longint unsigned x, y, t;
         x = n;
         y = d;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         if (x == 0) x = 1;
         n = n / x;
         d = d / x;
         if (n == 0) begin
            d = 1;
            neg = 0;
         end
         if (d == 0 || d > HALF - 1 || n > (neg ? HALF : HALF - 1)) begin
            r.status = rna_pkg::ST_OVF;
         end else begin
            r.num = neg ? -n[31:0] : n[31:0];
            r.den = d[30:0];
         end
      endfunction

      function void note(input logic [2:0] cmd, input logic [31:0] an, input logic [31:0] ad,
                         input logic [31:0] bn, input logic [31:0] bd);
         frac_result_type r;
         bit nn, dn, aneg, bneg;
         longint unsigned a_n, a_d, b_n, b_d, x, y;
         r = '{num: 0, den: 1, less: 0, equal: 0, status: rna_pkg::ST_OK};
         split(an, nn, a_n);
         split(ad, dn, a_d);
         aneg = (nn != dn) && a_n != 0;
         split(bn, nn, b_n);
         split(bd, dn, b_d);
         bneg = (nn != dn) && b_n != 0;
         if (cmd <= rna_pkg::CMD_NORM) begin
            if (a_d == 0 || (cmd != rna_pkg::CMD_NORM && b_d == 0)) begin
               r.status = rna_pkg::ST_DIV0;
            end else begin
               case (cmd)
                  rna_pkg::CMD_ADD, rna_pkg::CMD_SUB: begin
                     if (cmd == rna_pkg::CMD_SUB && b_n != 0) bneg = !bneg;
                     x = a_n * b_d;
                     y = b_n * a_d;
                     if (aneg == bneg) reduce(aneg, x + y, a_d * b_d, r);
                     else if (x >= y) reduce(aneg, x - y, a_d * b_d, r);
                     else reduce(bneg, y - x, a_d * b_d, r);
                  end
                  rna_pkg::CMD_MUL: reduce(aneg != bneg, a_n * b_n, a_d * b_d, r);
                  rna_pkg::CMD_DIV: begin
                     if (b_n == 0) r.status = rna_pkg::ST_DIV0;
                     else reduce(aneg != bneg, a_n * b_d, a_d * b_n, r);
                  end
                  rna_pkg::CMD_CMP: begin
                     x = a_n * b_d;
                     y = b_n * a_d;
                     if (aneg != bneg) begin
                        r.less = aneg;
                     end else begin
                        r.less = aneg ? (x > y) : (x < y);
                        r.equal = (x == y);
                     end
                  end
                  default: reduce(aneg, a_n, a_d, r);
               endcase
            end
         end
         pending.push_back(r);
      endfunction

      task report_mismatch(input string msg);
         $display("error: %s", msg);
         errors++;
      endtask

      task check(input frac_result_type got);
         frac_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("result beat with nothing pending");
            return;
         end
         e = pending.pop_front();
         if (got.num !== e.num) report_mismatch($sformatf("num %0d exp %0d", got.num, e.num));
         if (got.den !== e.den) report_mismatch($sformatf("den %0d exp %0d", got.den, e.den));
         if (got.less !== e.less) report_mismatch("cmp_less");
         if (got.equal !== e.equal) report_mismatch("cmp_equal");
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d exp %0d", got.status, e.status));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_cmd;
   logic signed [31:0] req_a_num, req_a_den, req_b_num, req_b_den;
   logic               rsp_valid;
   logic signed [31:0] rsp_res_num;
   logic [30:0]        rsp_res_den;
   logic               rsp_cmp_less, rsp_cmp_equal;
   logic [1:0]         rsp_status;

   frac_scoreboard sb = new();
   int             idle_cycles;

   rational_number_alu u_top (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1;
      start = 0;
      req_cmd = 0;
      req_a_num = 0;
      req_a_den = 1;
      req_b_num = 0;
      req_b_den = 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check('{rsp_res_num, rsp_res_den, rsp_cmp_less, rsp_cmp_equal, rsp_status});
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 50000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3: return $urandom_range(0, 1) ? 32'hffff_ffff : 1;
         4, 5: return $urandom;
         6: return $urandom_range(0, 1) ? $urandom_range(0, 65535) : -$urandom_range(0, 65535);
         default: return $urandom_range(0, 1) ? $urandom_range(1, 40) : -$urandom_range(1, 40);
      endcase
   endfunction

   task automatic send_beat(input logic [2:0] cmd, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [31:0] bd);
      start <= 1;
      req_cmd <= cmd;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (busy);
      sb.note(cmd, an, ad, bn, bd);
   endtask

   task automatic pause_sender();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [2:0] op;
      logic [31:0] d;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_beat(rna_pkg::CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
      send_beat(rna_pkg::CMD_SUB, 32'h8000_0000, 1, 1, 1);
      send_beat(rna_pkg::CMD_MUL, 32'h8000_0000, 1, 32'hffff_ffff, 1);
      send_beat(rna_pkg::CMD_DIV, 3, 4, 0, 5);
      send_beat(rna_pkg::CMD_DIV, 3, 0, 1, 5);
      send_beat(rna_pkg::CMD_ADD, 1, 2, 1, 0);
      send_beat(rna_pkg::CMD_CMP, 1, 2, 2, 4);
      send_beat(rna_pkg::CMD_CMP, -1, 2, 1, -3);
      send_beat(rna_pkg::CMD_CMP, 1, -2, -1, 3);
      send_beat(rna_pkg::CMD_NORM, 6, -8, 0, 0);
      send_beat(rna_pkg::CMD_NORM, 0, 32'h8000_0000, 5, 5);
      send_beat(rna_pkg::CMD_NORM, 7, 0, 1, 1);
      send_beat(rna_pkg::CMD_NORM, 32'h8000_0000, 32'hffff_ffff, 1, 1);
      send_beat(rna_pkg::CMD_DIV, 1, 32'h7fff_ffff, 32'h7fff_fffe, 1);
      send_beat(3'd6, 5, 7, 1, 1);
      send_beat(3'd7, 5, 0, 1, 0);
      send_beat(rna_pkg::CMD_MUL, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      drain();
      for (int i = 0; i < 1550; i++) begin
         op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
         d = rand_value();
         if (d == 0 && $urandom_range(0, 3) != 0) d = 1;
         send_beat(op, rand_value(), d, rand_value(), $urandom_range(0, 15) ? rand_value() | 1 : 0);
         if (i == 700) drain();
         pause_sender();
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
